// ===== rtl/cau_pkg.sv =====
package cau_pkg;

  localparam int DATA_W = 16;
  localparam int FRAC_W = 8;
  localparam int PROD_W = 2 * DATA_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int DIR_W  = SUM_W - FRAC_W;
  localparam int NUM_W  = PROD_W + FRAC_W;
  localparam int QW     = DATA_W;
  localparam int REM_W  = PROD_W + QW;

  localparam logic [2:0] OP_ADD  = 3'd0;
  localparam logic [2:0] OP_SUB  = 3'd1;
  localparam logic [2:0] OP_MUL  = 3'd2;
  localparam logic [2:0] OP_DIV  = 3'd3;
  localparam logic [2:0] OP_CONJ = 3'd4;

  localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef struct packed {
    logic [2:0]               opcode;
    logic signed [DATA_W-1:0] a_real;
    logic signed [DATA_W-1:0] a_imag;
    logic signed [DATA_W-1:0] b_real;
    logic signed [DATA_W-1:0] b_imag;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] res_real;
    logic signed [DATA_W-1:0] res_imag;
    logic                     overflow;
    logic                     div_zero;
  } rsp_t;

  typedef struct packed {
    logic              is_div;
    logic              dz;
    logic              ovf_d;
    logic [DATA_W-1:0] re_d;
    logic [DATA_W-1:0] im_d;
    logic              neg_re;
    logic              neg_im;
    logic              big_re;
    logic              big_im;
    logic [REM_W-1:0]  rem_re;
    logic [REM_W-1:0]  rem_im;
    logic [QW-1:0]     q_re;
    logic [QW-1:0]     q_im;
    logic [PROD_W-1:0] den;
  } div_t;

endpackage

// ===== rtl/cau_front.sv =====
module cau_front import cau_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  req_t din,
  output logic out_valid,
  output div_t dout
);

  typedef struct packed {
    logic [2:0]               opcode;
    logic signed [DATA_W-1:0] ar;
    logic signed [DATA_W-1:0] ai;
    logic signed [DATA_W-1:0] br;
    logic signed [DATA_W-1:0] bi;
    logic signed [PROD_W-1:0] p_rr;
    logic signed [PROD_W-1:0] p_ii;
    logic signed [PROD_W-1:0] p_ri;
    logic signed [PROD_W-1:0] p_ir;
    logic [PROD_W-1:0]        d_rr;
    logic [PROD_W-1:0]        d_ii;
  } prod_t;

  typedef struct packed {
    logic                    is_div;
    logic signed [DIR_W-1:0] dre;
    logic signed [DIR_W-1:0] dim;
    logic signed [SUM_W-1:0] nre;
    logic signed [SUM_W-1:0] nim;
    logic [PROD_W-1:0]       den;
  } sum_t;

  function automatic logic [DATA_W:0] sat_dir(input logic signed [DIR_W-1:0] x);
    logic [DATA_W:0] r;
    if (x > DIR_W'(SAT_MAX)) begin
      r = {1'b1, SAT_MAX};
    end else if (x < DIR_W'(SAT_MIN)) begin
      r = {1'b1, SAT_MIN};
    end else begin
      r = {1'b0, x[DATA_W-1:0]};
    end
    return r;
  endfunction

  logic  v1;
  prod_t p1;
  logic  v2;
  sum_t  s2;
  sum_t  s2_next;
  div_t  d3_next;

  // products
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1.opcode <= din.opcode;
      p1.ar     <= din.a_real;
      p1.ai     <= din.a_imag;
      p1.br     <= din.b_real;
      p1.bi     <= din.b_imag;
      p1.p_rr   <= din.a_real * din.b_real;
      p1.p_ii   <= din.a_imag * din.b_imag;
      p1.p_ri   <= din.a_real * din.b_imag;
      p1.p_ir   <= din.a_imag * din.b_real;
      p1.d_rr   <= din.b_real * din.b_real;
      p1.d_ii   <= din.b_imag * din.b_imag;
    end
  end

  // sums
  always_comb begin
    logic signed [SUM_W-1:0] mre;
    logic signed [SUM_W-1:0] mim;
    mre = SUM_W'(p1.p_rr) - SUM_W'(p1.p_ii);
    mim = SUM_W'(p1.p_ri) + SUM_W'(p1.p_ir);
    s2_next.is_div = (p1.opcode == OP_DIV);
    s2_next.nre = SUM_W'(p1.p_rr) + SUM_W'(p1.p_ii);
    s2_next.nim = SUM_W'(p1.p_ir) - SUM_W'(p1.p_ri);
    s2_next.den = p1.d_rr + p1.d_ii;
    s2_next.dre = '0;
    s2_next.dim = '0;
    case (p1.opcode)
      OP_ADD: begin
        s2_next.dre = DIR_W'(p1.ar) + DIR_W'(p1.br);
        s2_next.dim = DIR_W'(p1.ai) + DIR_W'(p1.bi);
      end
      OP_SUB: begin
        s2_next.dre = DIR_W'(p1.ar) - DIR_W'(p1.br);
        s2_next.dim = DIR_W'(p1.ai) - DIR_W'(p1.bi);
      end
      OP_MUL: begin
        s2_next.dre = mre[SUM_W-1:FRAC_W];
        s2_next.dim = mim[SUM_W-1:FRAC_W];
      end
      OP_CONJ: begin
        s2_next.dre = DIR_W'(p1.ar);
        s2_next.dim = -DIR_W'(p1.ai);
      end
      default: begin
        s2_next.dre = '0;
        s2_next.dim = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2 <= s2_next;
    end
  end

  // magnitudes, range check, direct saturation
  always_comb begin
    logic [SUM_W-1:0]  mag_re;
    logic [SUM_W-1:0]  mag_im;
    logic [NUM_W-1:0]  num_re;
    logic [NUM_W-1:0]  num_im;
    logic [REM_W-1:0]  lim;
    logic [DATA_W:0]   sr;
    logic [DATA_W:0]   si;
    mag_re = s2.nre[SUM_W-1] ? -s2.nre : s2.nre;
    mag_im = s2.nim[SUM_W-1] ? -s2.nim : s2.nim;
    num_re = {mag_re[PROD_W-1:0], {FRAC_W{1'b0}}};
    num_im = {mag_im[PROD_W-1:0], {FRAC_W{1'b0}}};
    lim = {s2.den, {QW{1'b0}}};
    sr = sat_dir(s2.dre);
    si = sat_dir(s2.dim);
    d3_next.is_div = s2.is_div;
    d3_next.dz     = (s2.den == '0);
    d3_next.ovf_d  = sr[DATA_W] | si[DATA_W];
    d3_next.re_d   = sr[DATA_W-1:0];
    d3_next.im_d   = si[DATA_W-1:0];
    d3_next.neg_re = s2.nre[SUM_W-1];
    d3_next.neg_im = s2.nim[SUM_W-1];
    d3_next.big_re = REM_W'(num_re) >= lim;
    d3_next.big_im = REM_W'(num_im) >= lim;
    d3_next.rem_re = REM_W'(num_re);
    d3_next.rem_im = REM_W'(num_im);
    d3_next.q_re   = '0;
    d3_next.q_im   = '0;
    d3_next.den    = s2.den;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= d3_next;
    end
  end

endmodule

// ===== rtl/cau_div.sv =====
module cau_div import cau_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  div_t din,
  output logic out_valid,
  output div_t dout
);

  logic vs [QW];
  div_t ds [QW];

  for (genvar k = 0; k < QW; k++) begin : g_step
    localparam int BIT = QW - 1 - k;
    logic src_v;
    div_t src;
    div_t step_next;

    if (k == 0) begin : g_first
      assign src_v = in_valid;
      assign src   = din;
    end else begin : g_rest
      assign src_v = vs[k-1];
      assign src   = ds[k-1];
    end

    always_comb begin
      logic [REM_W-1:0] sh;
      sh = REM_W'(src.den) << BIT;
      step_next = src;
      if (src.rem_re >= sh) begin
        step_next.rem_re = src.rem_re - sh;
        step_next.q_re[BIT] = 1'b1;
      end
      if (src.rem_im >= sh) begin
        step_next.rem_im = src.rem_im - sh;
        step_next.q_im[BIT] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vs[k] <= 1'b0;
      end else if (en) begin
        vs[k] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ds[k] <= step_next;
      end
    end
  end

  assign out_valid = vs[QW-1];
  assign dout      = ds[QW-1];

endmodule

// ===== rtl/cau_back.sv =====
module cau_back import cau_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  div_t din,
  output logic out_valid,
  output rsp_t dout
);

  function automatic logic [DATA_W:0] quot(input logic neg, input logic big,
                                           input logic [QW-1:0] q);
    logic [DATA_W:0] r;
    if (!neg) begin
      if (big || q[QW-1]) begin
        r = {1'b1, SAT_MAX};
      end else begin
        r = {1'b0, q};
      end
    end else begin
      if (big || (q > QW'(SAT_MIN))) begin
        r = {1'b1, SAT_MIN};
      end else begin
        r = {1'b0, -q};
      end
    end
    return r;
  endfunction

  rsp_t rsp_next;

  always_comb begin
    logic [DATA_W:0] qr;
    logic [DATA_W:0] qi;
    qr = quot(din.neg_re, din.big_re, din.q_re);
    qi = quot(din.neg_im, din.big_im, din.q_im);
    if (!din.is_div) begin
      rsp_next.res_real = din.re_d;
      rsp_next.res_imag = din.im_d;
      rsp_next.overflow = din.ovf_d;
      rsp_next.div_zero = 1'b0;
    end else if (din.dz) begin
      rsp_next.res_real = '0;
      rsp_next.res_imag = '0;
      rsp_next.overflow = 1'b0;
      rsp_next.div_zero = 1'b1;
    end else begin
      rsp_next.res_real = qr[DATA_W-1:0];
      rsp_next.res_imag = qi[DATA_W-1:0];
      rsp_next.overflow = qr[DATA_W] | qi[DATA_W];
      rsp_next.div_zero = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= rsp_next;
    end
  end

endmodule

// ===== rtl/complex_arith_unit.sv =====
// complex arithmetic unit on signed Q8.8 operands
// request channel req: one beat carries an opcode (add, subtract, multiply,
// divide, conjugate A) and the complex operands A and B
// response channel rsp: one beat per request, real and imaginary parts
// saturated to 16 bits, with overflow and divide-by-zero flags
// both channels: a beat moves on a rising edge with valid high and stall low
// throughput: one beat per cycle, every opcode, while no response is held
// path: a request beat passes the product, sum and range stages, the 16-step
// restoring divider pipeline (one quotient bit per stage) and the response
// register before it leaves as a response beat
// all opcodes run the full pipe, so responses leave in request order
// reset: synchronous, clears all stage valid bits; the first request may
// follow in the next cycle
// receiver stall: while a response is held, the whole pipe freezes and
// req_stall is raised; nothing is dropped or repeated
module complex_arith_unit import cau_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  logic en;
  logic fv;
  div_t fd;
  logic dv;
  div_t dd;

  assign en        = !(rsp_valid && rsp_stall);
  assign req_stall = !en;

  cau_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (req_valid),
    .din       (req),
    .out_valid (fv),
    .dout      (fd)
  );

  cau_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (fv),
    .din       (fd),
    .out_valid (dv),
    .dout      (dd)
  );

  cau_back u_back (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (dv),
    .din       (dd),
    .out_valid (rsp_valid),
    .dout      (rsp)
  );

endmodule

// ===== rtl/cau_checker.sv =====
module cau_checker import cau_pkg::*; (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_stall,
  input req_t req,
  input logic rsp_valid,
  input logic rsp_stall,
  input rsp_t rsp
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled response changed");

  a_req_hold: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_stall |=> req_valid && $stable(req))
    else $error("stalled request changed");

  a_backpressure: assert property (@(posedge clk)
    req_stall == (rsp_valid && rsp_stall))
    else $error("request stall does not follow held response");

  a_dz: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.div_zero |->
      rsp.res_real == '0 && rsp.res_imag == '0 && !rsp.overflow)
    else $error("divide by zero response not clean");

  a_reset: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid after reset");

endmodule

bind complex_arith_unit cau_checker u_cau_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);

// ===== tb/tb_top.sv =====
module tb_top;
  import cau_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  class cplx_scoreboard;
    rsp_t pending[$];
    int   errors;

    function automatic logic signed [15:0] clamp(longint x, ref logic ovf);
      if (x > 32767) begin
        ovf = 1'b1;
        return 16'sd32767;
      end
      if (x < -32768) begin
        ovf = 1'b1;
        return -16'sd32768;
      end
      return x[15:0];
    endfunction

    function automatic longint floor_q(longint x);
      return x >>> FRAC_W;
    endfunction

    function void note_request(req_t r);
      longint ar, ai, br, bi, re, im, den;
      logic   ovf;
      rsp_t   e;
      ar = r.a_real;
      ai = r.a_imag;
      br = r.b_real;
      bi = r.b_imag;
      re = 0;
      im = 0;
      ovf = 1'b0;
      e.div_zero = 1'b0;
      case (r.opcode)
        OP_ADD: begin
          re = ar + br;
          im = ai + bi;
        end
        OP_SUB: begin
          re = ar - br;
          im = ai - bi;
        end
        OP_MUL: begin
          re = floor_q(ar * br - ai * bi);
          im = floor_q(ar * bi + ai * br);
        end
        OP_DIV: begin
          den = br * br + bi * bi;
          if (den == 0) e.div_zero = 1'b1;
          else begin
            re = ((ar * br + ai * bi) * (64'sd1 << FRAC_W)) / den;
            im = ((ai * br - ar * bi) * (64'sd1 << FRAC_W)) / den;
          end
        end
        OP_CONJ: begin
          re = ar;
          im = -ai;
        end
        default: ;
      endcase
      e.res_real = clamp(re, ovf);
      e.res_imag = clamp(im, ovf);
      e.overflow = ovf;
      pending.push_back(e);
    endfunction

    function void check_response(rsp_t got);
      rsp_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected response %h", $time, got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.res_real !== e.res_real)
        $display("%0t: res_real expected %h actual %h", $time, e.res_real, got.res_real);
      if (got.res_imag !== e.res_imag)
        $display("%0t: res_imag expected %h actual %h", $time, e.res_imag, got.res_imag);
      if (got.overflow !== e.overflow)
        $display("%0t: overflow expected %b actual %b", $time, e.overflow, got.overflow);
      if (got.div_zero !== e.div_zero)
        $display("%0t: div_zero expected %b actual %b", $time, e.div_zero, got.div_zero);
      if (got !== e) errors++;
    endfunction
  endclass

  logic clk, rst;
  logic req_valid, req_stall, rsp_valid, rsp_stall;
  req_t req;
  rsp_t rsp;

  cplx_scoreboard sb;
  bit   calm;
  bit   hold_off;
  bit   sent_all;
  int   idle_cycles;

  complex_arith_unit dut (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_stall(req_stall),
    .req(req), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [15:0] pick_operand();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'($signed($urandom_range(0, 1023)) - 512);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_beat(req_t r);
    req_valid <= 1'b1;
    req <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    sb.note_request(r);
  endtask

  task automatic random_gap();
    int n;
    if (!calm && $urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, 14);
      req_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_op(logic [2:0] op, logic [15:0] ar, logic [15:0] ai,
                         logic [15:0] br, logic [15:0] bi);
    req_t r;
    r.opcode = op;
    r.a_real = ar;
    r.a_imag = ai;
    r.b_real = br;
    r.b_imag = bi;
    send_beat(r);
  endtask

  initial begin
    req_t r;
    sb = new();
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    calm = 1'b0;
    hold_off = 1'b0;
    sent_all = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    send_op(OP_ADD, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
    send_op(OP_ADD, 16'h0100, 16'hff00, 16'h0080, 16'h0000);
    send_op(OP_SUB, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
    send_op(OP_SUB, 16'h0000, 16'h0000, 16'h8000, 16'h8000);
    send_op(OP_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_op(OP_MUL, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
    send_op(OP_MUL, 16'hffff, 16'h0000, 16'h0001, 16'h0000);
    send_op(OP_MUL, 16'h0180, 16'hfe80, 16'h0200, 16'h0000);
    send_op(OP_DIV, 16'h0100, 16'h0100, 16'h0000, 16'h0000);
    send_op(OP_DIV, 16'h7fff, 16'h8000, 16'h0001, 16'h0000);
    send_op(OP_DIV, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_op(OP_DIV, 16'hff00, 16'h0300, 16'h0000, 16'h0200);
    send_op(OP_DIV, 16'h0001, 16'hffff, 16'h7fff, 16'h0003);
    send_op(OP_CONJ, 16'h1234, 16'h8000, 16'h5555, 16'haaaa);
    send_op(OP_CONJ, 16'h8000, 16'h7fff, 16'h0000, 16'h0000);
    send_op(3'd5, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
    send_op(3'd6, 16'h1111, 16'h2222, 16'h3333, 16'h4444);
    send_op(3'd7, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
    for (int i = 0; i < 1350; i++) begin
      if (i == 300) hold_off = 1'b1;
      if (i == 1150) calm = 1'b1;
      r.opcode = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                              : 3'($urandom_range(0, 4));
      r.a_real = pick_operand();
      r.a_imag = pick_operand();
      r.b_real = pick_operand();
      r.b_imag = ($urandom_range(0, 4) == 0) ? 16'h0000 : pick_operand();
      if (r.opcode == OP_DIV && $urandom_range(0, 9) == 0) begin
        r.b_real = '0;
        r.b_imag = '0;
      end
      send_beat(r);
      random_gap();
    end
    req_valid <= 1'b0;
    sent_all = 1'b1;
  end

  initial begin
    int n;
    rsp_stall = 1'b0;
    @(negedge rst);
    forever begin
      if (hold_off) begin
        hold_off = 1'b0;
        rsp_stall <= 1'b1;
        repeat (60) @(posedge clk);
      end
      if (!calm && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 14);
        rsp_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      rsp_stall <= 1'b0;
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) sb.check_response(rsp);
  end

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    @(negedge rst);
    while (!(sent_all && sb.pending.size() == 0)) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("** complex_arith_unit: PASSED **");
    end else begin
      $display("** complex_arith_unit: FAILED **");
    end
    $finish;
  end

  initial begin
    wait (idle_cycles >= 2000);
    $display("** complex_arith_unit: FAILED **");
    $finish;
  end
endmodule
